// File: hdl/multi_channel_byte_fifo_unit_defines.svh
// assertion macros for the byte channel unit
`ifndef MULTI_CHANNEL_BYTE_FIFO_UNIT_DEFINES_SVH
`define MULTI_CHANNEL_BYTE_FIFO_UNIT_DEFINES_SVH

// same-cycle implication, ignored while reset is high
`define MCBF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mcbf assertion failed");

// next-cycle implication, ignored while reset is high
`define MCBF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mcbf assertion failed");

`endif

// File: hdl/mcbf_pkg.sv
`default_nettype none
package mcbf_pkg;

   localparam int NUM_CHANNELS  = 8;
   // power of two
   localparam int CHANNEL_DEPTH = 256;

   localparam int CH_W        = $clog2(NUM_CHANNELS);
   localparam int SLOT_W      = $clog2(CHANNEL_DEPTH);
   localparam int PTR_W       = SLOT_W + 1;
   localparam int STORE_DEPTH = NUM_CHANNELS * CHANNEL_DEPTH;
   localparam int ADDR_W      = CH_W + SLOT_W;

   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_READ  = 2'd1,
      KIND_ALLOC = 2'd2,
      KIND_FREE  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_NOT_IN_USE = 3'd1,
      ST_EMPTY      = 3'd2,
      ST_FULL       = 3'd3,
      ST_NO_FREE    = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOKUP,
      S_FETCH
   } state_type;

   typedef struct packed {
      logic [PTR_W-1:0] rd;
      logic [PTR_W-1:0] wr;
   } ptr_entry_type;

   // in_use after reset: channels 0 and 1
   localparam logic [NUM_CHANNELS-1:0] IN_USE_RESET = NUM_CHANNELS'(2'b11);

endpackage
`default_nettype wire

// File: hdl/multi_channel_byte_fifo_unit.sv
`default_nettype none
// Byte channel engine: NUM_CHANNELS ring buffers of CHANNEL_DEPTH bytes share one byte
// memory, and their read/write pointers live in a small pointer memory. One request is
// worked at a time: the request cycle reads the pointer entry, the lookup state checks
// it and, once the result register is free, writes back the pointer and, for a write,
// the byte. A read then passes through a fetch state for the byte memory read. The
// result register lets the next request be taken while a result waits; a request only
// commits once that register is free. No clearing pass is needed after reset.
`include "multi_channel_byte_fifo_unit_defines.svh"

module multi_channel_byte_fifo_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_kind,
   input  wire logic [2:0] req_channel,
   input  wire logic [7:0] req_data_in,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [2:0]      rsp_status,
   output logic [7:0]      rsp_data_out,
   output logic [2:0]      rsp_granted_channel
);

   localparam int NCH   = mcbf_pkg::NUM_CHANNELS;
   localparam int CH_W  = mcbf_pkg::CH_W;
   localparam int PTR_W = mcbf_pkg::PTR_W;
   localparam int SLOT_W = mcbf_pkg::SLOT_W;
   localparam int ADDR_W = mcbf_pkg::ADDR_W;

   mcbf_pkg::state_type     state_ff, state_in;
   mcbf_pkg::kind_type      kind_ff;
   logic [2:0]              channel_ff;
   logic [7:0]              data_ff;

   mcbf_pkg::ptr_entry_type ptr_mem [NCH];
   mcbf_pkg::ptr_entry_type ptr_rd_ff;
   logic                    ptr_hit_ff;
   logic [NCH-1:0]          ptr_vld_ff;
   logic [NCH-1:0]          in_use_ff;

   logic [7:0]              byte_mem [mcbf_pkg::STORE_DEPTH];
   logic [7:0]              byte_rd_ff;

   logic                    rsp_valid_ff;
   mcbf_pkg::status_type    rsp_status_ff;
   logic [7:0]              rsp_data_ff;
   logic [2:0]              rsp_grant_ff;

   // handshake / control
   logic                    accept;
   logic                    out_free;
   logic                    commit;
   logic                    rsp_load;

   // lookup decode
   logic [CH_W-1:0]         ch_idx;
   logic                    live;
   mcbf_pkg::ptr_entry_type ptr_cur;
   logic [PTR_W-1:0]        fill;
   logic                    is_empty;
   logic                    is_full;
   logic                    free_found;
   logic [CH_W-1:0]         free_idx;
   mcbf_pkg::status_type    lk_status;
   logic [2:0]              lk_grant;
   logic                    read_ok;
   logic                    byte_we;
   logic [ADDR_W-1:0]       byte_addr;
   logic                    ptr_we;
   logic [CH_W-1:0]         ptr_waddr;
   mcbf_pkg::ptr_entry_type ptr_wdata;
   logic                    use_set;
   logic                    use_clr;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mcbf_pkg::S_IDLE: begin
            if (req_valid) state_in = mcbf_pkg::S_LOOKUP;
         end
         mcbf_pkg::S_LOOKUP: begin
            if (out_free) state_in = read_ok ? mcbf_pkg::S_FETCH : mcbf_pkg::S_IDLE;
         end
         mcbf_pkg::S_FETCH: begin
            if (out_free) state_in = mcbf_pkg::S_IDLE;
         end
         default: state_in = mcbf_pkg::S_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      commit    = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         mcbf_pkg::S_IDLE:   req_ready = 1'b1;
         mcbf_pkg::S_LOOKUP: begin
            commit   = out_free;
            rsp_load = out_free && !read_ok;
         end
         mcbf_pkg::S_FETCH:  rsp_load = out_free;
         default: ;
      endcase
   end

   // lowest free channel
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = NCH - 1; i >= 0; i--) begin
         if (!in_use_ff[i]) begin
            free_found = 1'b1;
            free_idx   = CH_W'(i);
         end
      end
   end

   // check the request against the pointer entry
   always_comb begin
      ch_idx    = CH_W'(channel_ff);
      live      = (32'(channel_ff) < NCH) && in_use_ff[ch_idx];
      ptr_cur   = ptr_hit_ff ? ptr_rd_ff : '0;
      fill      = ptr_cur.wr - ptr_cur.rd;
      is_empty  = (fill == '0);
      is_full   = (32'(fill) >= mcbf_pkg::CHANNEL_DEPTH);
      lk_status = mcbf_pkg::ST_OK;
      lk_grant  = '0;
      read_ok   = 1'b0;
      byte_we   = 1'b0;
      byte_addr = {ch_idx, ptr_cur.wr[SLOT_W-1:0]};
      ptr_we    = 1'b0;
      ptr_waddr = ch_idx;
      ptr_wdata = ptr_cur;
      use_set   = 1'b0;
      use_clr   = 1'b0;
      case (kind_ff)
         mcbf_pkg::KIND_WRITE: begin
            if (!live) lk_status = mcbf_pkg::ST_NOT_IN_USE;
            else if (is_full) lk_status = mcbf_pkg::ST_FULL;
            else begin
               byte_we      = 1'b1;
               ptr_we       = 1'b1;
               ptr_wdata.wr = ptr_cur.wr + PTR_W'(1);
            end
         end
         mcbf_pkg::KIND_READ: begin
            byte_addr = {ch_idx, ptr_cur.rd[SLOT_W-1:0]};
            if (!live) lk_status = mcbf_pkg::ST_NOT_IN_USE;
            else if (is_empty) lk_status = mcbf_pkg::ST_EMPTY;
            else begin
               read_ok      = 1'b1;
               ptr_we       = 1'b1;
               ptr_wdata.rd = ptr_cur.rd + PTR_W'(1);
            end
         end
         mcbf_pkg::KIND_ALLOC: begin
            ptr_waddr = free_idx;
            ptr_wdata = '0;
            if (!free_found) lk_status = mcbf_pkg::ST_NO_FREE;
            else begin
               lk_grant = 3'(free_idx);
               ptr_we   = 1'b1;
               use_set  = 1'b1;
            end
         end
         mcbf_pkg::KIND_FREE: begin
            if (!live) lk_status = mcbf_pkg::ST_NOT_IN_USE;
            else use_clr = 1'b1;
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mcbf_pkg::S_IDLE;
         in_use_ff    <= mcbf_pkg::IN_USE_RESET;
         ptr_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (commit && use_set) in_use_ff[ptr_waddr] <= 1'b1;
         if (commit && use_clr) in_use_ff[ch_idx] <= 1'b0;
         if (commit && ptr_we) ptr_vld_ff[ptr_waddr] <= 1'b1;
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // request capture and pointer memory read
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff    <= mcbf_pkg::kind_type'(req_kind);
         channel_ff <= req_channel;
         data_ff    <= req_data_in;
         ptr_rd_ff  <= ptr_mem[CH_W'(req_channel)];
         ptr_hit_ff <= ptr_vld_ff[CH_W'(req_channel)];
      end
   end

   // pointer memory write back
   always_ff @(posedge clock) begin
      if (commit && ptr_we) ptr_mem[ptr_waddr] <= ptr_wdata;
   end

   // byte memory
   always_ff @(posedge clock) begin
      if (commit && byte_we) byte_mem[byte_addr] <= data_ff;
      if (commit && read_ok) byte_rd_ff <= byte_mem[byte_addr];
   end

   // result word
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         if (state_ff == mcbf_pkg::S_FETCH) begin
            rsp_status_ff <= mcbf_pkg::ST_OK;
            rsp_data_ff   <= byte_rd_ff;
            rsp_grant_ff  <= '0;
         end else begin
            rsp_status_ff <= lk_status;
            rsp_data_ff   <= '0;
            rsp_grant_ff  <= lk_grant;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_data_out        = rsp_data_ff;
   assign rsp_granted_channel = rsp_grant_ff;

   // a result is only loaded into a free result register
   `MCBF_ASSERT_NOW(a_load_free, clock, reset, rsp_load, out_free)
   // a stored pointer pair never holds more than one channel's worth of bytes
   `MCBF_ASSERT_NOW(a_fill_bound, clock, reset, state_ff == mcbf_pkg::S_LOOKUP,
      32'(fill) <= mcbf_pkg::CHANNEL_DEPTH)
   // a granted channel was free and is in use afterwards
   `MCBF_ASSERT_NEXT(a_grant_free, clock, reset, commit && use_set, in_use_ff[$past(ptr_waddr)])

endmodule
`default_nettype wire
